[hw/rtl/char_lcd_tick_sequencer_top_macros.svh]
// Assertion macros for the character LCD tick sequencer.
`ifndef CHAR_LCD_TICK_SEQUENCER_TOP_MACROS_SVH
`define CHAR_LCD_TICK_SEQUENCER_TOP_MACROS_SVH

// Same-cycle implication, clocked on clk, off while arst_n is low.
`define LCDTS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, clocked on clk, off while arst_n is low.
`define LCDTS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/lcdts_pkg.sv]
// Shared types, codes, constants and the microcode table of the LCD tick sequencer.
`timescale 1ns / 1ps

package lcdts_pkg;

	localparam int TEXT_DEPTH_DEF = 64;
	localparam int DATA_PINS      = 8;
	localparam int NUM_DIGITS_MAX = 10;
	localparam int STEP_W         = 5;
	localparam int CFG_INDEX_W    = 2;
	localparam int CFG_DATA_W     = 7;

	// item modes
	localparam logic [2:0] MODE_TICK   = 3'd0;
	localparam logic [2:0] MODE_INIT   = 3'd1;
	localparam logic [2:0] MODE_CLEAR  = 3'd2;
	localparam logic [2:0] MODE_CURSOR = 3'd3;
	localparam logic [2:0] MODE_NUMBER = 3'd4;
	localparam logic [2:0] MODE_TEXT   = 3'd5;

	// config register indexes
	localparam logic [CFG_INDEX_W-1:0] CFG_LINE_COUNT   = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_COLUMN_COUNT = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_LINE3_BASE   = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_LINE4_BASE   = 2'd3;

	localparam logic [2:0] LINE_COUNT_RST   = 3'd2;
	localparam logic [5:0] COLUMN_COUNT_RST = 6'd16;
	localparam logic [6:0] LINE3_BASE_RST   = 7'h10;
	localparam logic [6:0] LINE4_BASE_RST   = 7'h50;
	localparam logic [6:0] LINE1_BASE       = 7'h00;
	localparam logic [6:0] LINE2_BASE       = 7'h40;

	localparam logic [DATA_PINS-1:0] CMD_FUNCTION_SET = 8'h38;
	localparam logic [DATA_PINS-1:0] CMD_DISPLAY_ON   = 8'h0E;
	localparam logic [DATA_PINS-1:0] CMD_CLEAR        = 8'h01;
	localparam logic [DATA_PINS-1:0] CMD_ENTRY_MODE   = 8'h06;
	localparam logic [DATA_PINS-1:0] CMD_SET_DDRAM    = 8'h80;
	localparam logic [DATA_PINS-1:0] ASCII_ZERO       = 8'h30;

	// ceil(2^35 / 10): floor(n / 10) == (n * DIV10_RECIP) >> 35 for 32-bit n
	localparam logic [31:0] DIV10_RECIP = 32'hCCCC_CCCD;

	localparam logic [2:0] INIT_STEP_POWER = 3'd0;
	localparam logic [2:0] INIT_STEP_LAST  = 3'd4;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_READY = 2'd1,
		ST_WRONG     = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		TOP_OFF  = 2'd0,
		TOP_INIT = 2'd1,
		TOP_RUN  = 2'd2
	} top_state_t;

	typedef enum logic [2:0] {
		KIND_NONE   = 3'd0,
		KIND_TEXT   = 3'd1,
		KIND_CLEAR  = 3'd2,
		KIND_CURSOR = 3'd3,
		KIND_NUMBER = 3'd4
	} kind_t;

	// microprogram addresses; fall-through order matters
	typedef enum logic [STEP_W-1:0] {
		S_INIT       = 5'd0,
		S_CLEAR      = 5'd1,
		S_CURSOR     = 5'd2,
		S_CURSOR_SET = 5'd3,
		S_NUM_START  = 5'd4,
		S_NUM_DIGIT  = 5'd5,
		S_NUM_END    = 5'd6,
		S_TEXT       = 5'd7,
		S_NOT_READY  = 5'd8,
		S_WRONG      = 5'd9,
		S_TK_INIT    = 5'd10,
		S_TK_CLEAR   = 5'd11,
		S_TK_CURSOR  = 5'd12,
		S_TK_READ    = 5'd13,
		S_TK_TEXT    = 5'd14,
		S_EMIT       = 5'd15,
		S_WAIT       = 5'd16,
		S_DISP       = 5'd17,
		S_TK_IDLE    = 5'd18
	} ustep_t;

	typedef enum logic [4:0] {
		A_NONE,
		A_INIT_REQ,
		A_CLEAR_REQ,
		A_CURSOR_REQ,
		A_NUM_START,
		A_NUM_DIGIT,
		A_NUM_END,
		A_TEXT_BYTE,
		A_NOT_READY,
		A_WRONG,
		A_TICK_INIT,
		A_TICK_CLEAR,
		A_TICK_CURSOR,
		A_TEXT_READ,
		A_TICK_TEXT,
		A_FINISH,
		A_EMIT
	} action_t;

	// jump conditions: taken -> tgt, else step + 1; dispatch is multiway
	typedef enum logic [2:0] {
		C_ALWAYS,
		C_NEXT,
		C_NO_INPUT,
		C_BAD_CURSOR,
		C_MORE_DIGITS,
		C_OUT_FULL,
		C_DISPATCH
	} cond_t;

	typedef struct packed {
		action_t act;
		cond_t   cond;
		ustep_t  tgt;
	} ucode_t;

	function automatic ucode_t ucode_rom(input ustep_t s);
		ucode_t w;
		case (s)
			S_INIT:       w = '{act: A_INIT_REQ,    cond: C_ALWAYS,      tgt: S_EMIT};
			S_CLEAR:      w = '{act: A_CLEAR_REQ,   cond: C_ALWAYS,      tgt: S_EMIT};
			S_CURSOR:     w = '{act: A_NONE,        cond: C_BAD_CURSOR,  tgt: S_WRONG};
			S_CURSOR_SET: w = '{act: A_CURSOR_REQ,  cond: C_ALWAYS,      tgt: S_EMIT};
			S_NUM_START:  w = '{act: A_NUM_START,   cond: C_NEXT,        tgt: S_NUM_DIGIT};
			S_NUM_DIGIT:  w = '{act: A_NUM_DIGIT,   cond: C_MORE_DIGITS, tgt: S_NUM_DIGIT};
			S_NUM_END:    w = '{act: A_NUM_END,     cond: C_ALWAYS,      tgt: S_EMIT};
			S_TEXT:       w = '{act: A_TEXT_BYTE,   cond: C_ALWAYS,      tgt: S_EMIT};
			S_NOT_READY:  w = '{act: A_NOT_READY,   cond: C_ALWAYS,      tgt: S_EMIT};
			S_WRONG:      w = '{act: A_WRONG,       cond: C_ALWAYS,      tgt: S_EMIT};
			S_TK_INIT:    w = '{act: A_TICK_INIT,   cond: C_ALWAYS,      tgt: S_EMIT};
			S_TK_CLEAR:   w = '{act: A_TICK_CLEAR,  cond: C_ALWAYS,      tgt: S_EMIT};
			S_TK_CURSOR:  w = '{act: A_TICK_CURSOR, cond: C_ALWAYS,      tgt: S_EMIT};
			S_TK_READ:    w = '{act: A_TEXT_READ,   cond: C_NEXT,        tgt: S_TK_TEXT};
			S_TK_TEXT:    w = '{act: A_TICK_TEXT,   cond: C_ALWAYS,      tgt: S_EMIT};
			S_EMIT:       w = '{act: A_EMIT,        cond: C_OUT_FULL,    tgt: S_EMIT};
			S_WAIT:       w = '{act: A_NONE,        cond: C_NO_INPUT,    tgt: S_WAIT};
			S_DISP:       w = '{act: A_NONE,        cond: C_DISPATCH,    tgt: S_WAIT};
			S_TK_IDLE:    w = '{act: A_FINISH,      cond: C_ALWAYS,      tgt: S_EMIT};
			default:      w = '{act: A_NONE,        cond: C_ALWAYS,      tgt: S_WAIT};
		endcase
		return w;
	endfunction

	function automatic logic [DATA_PINS-1:0] init_cmd(input logic [1:0] idx);
		logic [DATA_PINS-1:0] c;
		case (idx)
			2'd0:    c = CMD_FUNCTION_SET;
			2'd1:    c = CMD_DISPLAY_ON;
			2'd2:    c = CMD_CLEAR;
			default: c = CMD_ENTRY_MODE;
		endcase
		return c;
	endfunction

endpackage

[hw/rtl/lcdts_req_if.sv]
// Request channel: one tick or request item per beat.
`timescale 1ns / 1ps

interface lcdts_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  mode;
	logic [1:0]  row;
	logic [5:0]  column;
	logic [31:0] number;
	logic [7:0]  text_char;
	logic        text_last;

	modport source (output valid, mode, row, column, number, text_char, text_last,
		input ready);
	modport sink (input valid, mode, row, column, number, text_char, text_last,
		output ready);
endinterface

[hw/rtl/lcdts_res_if.sv]
// Result channel: status and LCD pin levels, one beat per request beat.
`timescale 1ns / 1ps

interface lcdts_res_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic [7:0] bus_data;
	logic       reg_select;
	logic       read_write;
	logic       enable;
	logic       pins_on;
	logic       busy_res;
	logic [1:0] controller_state;

	modport source (output valid, status, bus_data, reg_select, read_write, enable,
		pins_on, busy_res, controller_state, input ready);
	modport sink (input valid, status, bus_data, reg_select, read_write, enable,
		pins_on, busy_res, controller_state, output ready);
endinterface

[hw/rtl/char_lcd_tick_sequencer_top.sv]
// Top level: microcoded character LCD tick sequencer with text store.
// The block takes a new beat only once the last beat's result has been loaded into the result
//   register; the emit step waits while that register is held.
// A single step counter walks the microcode, one step a cycle except while it waits for a beat
//   or holds in the emit step, and decimal conversion yields one digit a cycle from a 32x32 multiply.
// Reset (arst_n low, async): controller off, pins and datapath state cleared, registers at defaults;
//   text store and request latch not cleared, no clearing pass.
`timescale 1ns / 1ps

module char_lcd_tick_sequencer_top #(
	parameter int TEXT_DEPTH = lcdts_pkg::TEXT_DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [lcdts_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [lcdts_pkg::CFG_DATA_W-1:0]   cfg_data,
	lcdts_req_if.sink                          req,
	lcdts_res_if.source                        res
);

	localparam int AW = $clog2(TEXT_DEPTH);
	localparam int CW = $clog2(TEXT_DEPTH) + 1;   // counts 0..TEXT_DEPTH

	// ---------------- configuration registers ----------------
	logic [2:0] line_count_q;
	logic [5:0] column_count_q;
	logic [6:0] line3_base_q;
	logic [6:0] line4_base_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_count_q   <= lcdts_pkg::LINE_COUNT_RST;
			column_count_q <= lcdts_pkg::COLUMN_COUNT_RST;
			line3_base_q   <= lcdts_pkg::LINE3_BASE_RST;
			line4_base_q   <= lcdts_pkg::LINE4_BASE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				lcdts_pkg::CFG_LINE_COUNT:   line_count_q   <= cfg_data[2:0];
				lcdts_pkg::CFG_COLUMN_COUNT: column_count_q <= cfg_data[5:0];
				lcdts_pkg::CFG_LINE3_BASE:   line3_base_q   <= cfg_data[6:0];
				lcdts_pkg::CFG_LINE4_BASE:   line4_base_q   <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// ---------------- sequencer and datapath state ----------------
	lcdts_pkg::ustep_t     step_q, step_d;
	lcdts_pkg::ucode_t     uw;
	lcdts_pkg::ustep_t     disp_tgt;
	lcdts_pkg::top_state_t top_q;
	lcdts_pkg::kind_t      kind_q;
	lcdts_pkg::status_t    st_q;
	logic [2:0]            init_step_q;
	logic                  en_q, busy_q, sub_q, pins_q, sel_q;
	logic [CW-1:0]         char_index_q, text_length_q, fill_q;
	logic [6:0]            ddram_q;
	logic [7:0]            cursor_q;
	logic [7:0]            bus_q;

	// latched request beat
	logic [2:0]  mode_q;
	logic [1:0]  row_q;
	logic [5:0]  col_q;
	logic [31:0] num_q;     // also the working value of the digit loop
	logic [7:0]  char_q;
	logic        last_q;

	// result register
	logic       res_valid_q;
	logic [1:0] res_status_q;
	logic [7:0] res_bus_q;
	logic       res_sel_q, res_en_q, res_pins_q, res_busy_q;
	logic [1:0] res_top_q;

	logic accept, out_free, ready, take;

	assign uw       = lcdts_pkg::ucode_rom(step_q);
	assign req.ready = (step_q == lcdts_pkg::S_WAIT);
	assign accept   = req.valid && req.ready;
	assign out_free = !res_valid_q || res.ready;
	assign ready    = (top_q == lcdts_pkg::TOP_RUN) && !busy_q;

	// ---------------- digit unit: n / 10 by reciprocal ----------------
	logic [63:0] prod;
	logic [28:0] quot;
	logic [31:0] quot_x10, rem;
	logic [7:0]  digit_char;

	assign prod       = 64'(num_q) * 64'(lcdts_pkg::DIV10_RECIP);
	assign quot       = prod[63:35];
	assign quot_x10   = 32'({quot, 3'b000}) + 32'({quot, 1'b0});
	assign rem        = num_q - quot_x10;
	assign digit_char = lcdts_pkg::ASCII_ZERO + {4'b0000, rem[3:0]};

	// ---------------- decode helpers ----------------
	logic       bad_cursor, more_digits;
	logic [6:0] line_base, ddram_next;
	logic [1:0] init_idx;

	assign bad_cursor  = ({1'b0, row_q} >= line_count_q) || (col_q >= column_count_q);
	assign more_digits = (quot != '0) &&
		(text_length_q < CW'(lcdts_pkg::NUM_DIGITS_MAX - 1));
	assign init_idx    = 2'(init_step_q - 3'd1);

	always_comb begin
		case (cursor_q[7:6])
			2'd0:    line_base = lcdts_pkg::LINE1_BASE;
			2'd1:    line_base = lcdts_pkg::LINE2_BASE;
			2'd2:    line_base = line3_base_q;
			default: line_base = line4_base_q;
		endcase
	end
	assign ddram_next = 7'(line_base + {1'b0, cursor_q[5:0]});

	// multiway dispatch on the latched beat and the controller state
	always_comb begin
		case (mode_q)
			lcdts_pkg::MODE_TICK: begin
				if (top_q == lcdts_pkg::TOP_INIT) begin
					disp_tgt = lcdts_pkg::S_TK_INIT;
				end else if (top_q != lcdts_pkg::TOP_RUN || !busy_q) begin
					disp_tgt = lcdts_pkg::S_EMIT;
				end else begin
					case (kind_q)
						lcdts_pkg::KIND_CLEAR:  disp_tgt = lcdts_pkg::S_TK_CLEAR;
						lcdts_pkg::KIND_CURSOR: disp_tgt = lcdts_pkg::S_TK_CURSOR;
						lcdts_pkg::KIND_TEXT,
						lcdts_pkg::KIND_NUMBER: disp_tgt = lcdts_pkg::S_TK_READ;
						default:                disp_tgt = lcdts_pkg::S_TK_IDLE;
					endcase
				end
			end
			lcdts_pkg::MODE_INIT:
				disp_tgt = (top_q == lcdts_pkg::TOP_OFF) ? lcdts_pkg::S_INIT
					: lcdts_pkg::S_NOT_READY;
			lcdts_pkg::MODE_CLEAR:
				disp_tgt = ready ? lcdts_pkg::S_CLEAR : lcdts_pkg::S_NOT_READY;
			lcdts_pkg::MODE_CURSOR:
				disp_tgt = ready ? lcdts_pkg::S_CURSOR : lcdts_pkg::S_NOT_READY;
			lcdts_pkg::MODE_NUMBER:
				disp_tgt = ready ? lcdts_pkg::S_NUM_START : lcdts_pkg::S_NOT_READY;
			lcdts_pkg::MODE_TEXT:
				disp_tgt = ready ? lcdts_pkg::S_TEXT : lcdts_pkg::S_NOT_READY;
			default:
				disp_tgt = lcdts_pkg::S_WRONG;
		endcase
	end

	// ---------------- step counter ----------------
	always_comb begin
		case (uw.cond)
			lcdts_pkg::C_ALWAYS:      take = 1'b1;
			lcdts_pkg::C_NEXT:        take = 1'b0;
			lcdts_pkg::C_NO_INPUT:    take = !req.valid;
			lcdts_pkg::C_BAD_CURSOR:  take = bad_cursor;
			lcdts_pkg::C_MORE_DIGITS: take = more_digits;
			lcdts_pkg::C_OUT_FULL:    take = !out_free;
			default:                  take = 1'b0;
		endcase
		if (uw.cond == lcdts_pkg::C_DISPATCH) begin
			step_d = disp_tgt;
		end else if (take) begin
			step_d = uw.tgt;
		end else begin
			step_d = lcdts_pkg::ustep_t'(step_q + 5'd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= lcdts_pkg::S_WAIT;
		end else begin
			step_q <= step_d;
		end
	end

	// ---------------- text store ----------------
	logic [7:0]    text_mem [TEXT_DEPTH];
	logic [7:0]    rd_q;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [7:0]    mem_wdata;
	logic [CW-1:0] rd_idx;
	logic          fill_room;

	assign fill_room = (fill_q < CW'(TEXT_DEPTH));
	assign mem_we    = (uw.act == lcdts_pkg::A_NUM_DIGIT) ||
		((uw.act == lcdts_pkg::A_TEXT_BYTE) && fill_room);
	// digits go in least significant first and are read back reversed
	assign mem_waddr = (uw.act == lcdts_pkg::A_NUM_DIGIT) ? text_length_q[AW-1:0]
		: fill_q[AW-1:0];
	assign mem_wdata = (uw.act == lcdts_pkg::A_NUM_DIGIT) ? digit_char : char_q;
	assign rd_idx    = (kind_q == lcdts_pkg::KIND_NUMBER)
		? (text_length_q - char_index_q - CW'(1)) : char_index_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			text_mem[mem_waddr] <= mem_wdata;
		end
		if (uw.act == lcdts_pkg::A_TEXT_READ) begin
			rd_q <= text_mem[rd_idx[AW-1:0]];
		end
	end

	// ---------------- request latch ----------------
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= req.mode;
			row_q  <= req.row;
			col_q  <= req.column;
			char_q <= req.text_char;
			last_q <= req.text_last;
		end
		if (accept) begin
			num_q <= req.number;
		end else if (uw.act == lcdts_pkg::A_NUM_DIGIT) begin
			num_q <= 32'(quot);
		end
	end

	// ---------------- datapath, one action per step ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q         <= lcdts_pkg::TOP_OFF;
			init_step_q   <= lcdts_pkg::INIT_STEP_POWER;
			en_q          <= 1'b0;
			busy_q        <= 1'b0;
			kind_q        <= lcdts_pkg::KIND_NONE;
			sub_q         <= 1'b0;
			char_index_q  <= '0;
			text_length_q <= '0;
			fill_q        <= '0;
			ddram_q       <= '0;
			cursor_q      <= '0;
			bus_q         <= '0;
			sel_q         <= 1'b0;
			pins_q        <= 1'b0;
			st_q          <= lcdts_pkg::ST_OK;
		end else begin
			if (accept) begin
				st_q <= lcdts_pkg::ST_OK;
			end
			case (uw.act)
				lcdts_pkg::A_INIT_REQ: begin
					top_q       <= lcdts_pkg::TOP_INIT;
					init_step_q <= lcdts_pkg::INIT_STEP_POWER;
				end
				lcdts_pkg::A_CLEAR_REQ: begin
					busy_q <= 1'b1;
					kind_q <= lcdts_pkg::KIND_CLEAR;
					sub_q  <= 1'b0;
				end
				lcdts_pkg::A_CURSOR_REQ: begin
					cursor_q <= {row_q, col_q};
					busy_q   <= 1'b1;
					kind_q   <= lcdts_pkg::KIND_CURSOR;
					sub_q    <= 1'b0;
				end
				lcdts_pkg::A_NUM_START: begin
					text_length_q <= '0;
					fill_q        <= '0;
				end
				lcdts_pkg::A_NUM_DIGIT: begin
					text_length_q <= text_length_q + CW'(1);
				end
				lcdts_pkg::A_NUM_END: begin
					busy_q <= 1'b1;
					kind_q <= lcdts_pkg::KIND_NUMBER;
					sub_q  <= 1'b0;
				end
				lcdts_pkg::A_TEXT_BYTE: begin
					if (!fill_room) begin
						st_q <= lcdts_pkg::ST_FULL;
					end
					if (last_q) begin
						// last byte starts the write with whatever fit
						text_length_q <= fill_room ? fill_q + CW'(1) : fill_q;
						fill_q        <= '0;
						busy_q        <= 1'b1;
						kind_q        <= lcdts_pkg::KIND_TEXT;
						sub_q         <= 1'b0;
					end else if (fill_room) begin
						fill_q <= fill_q + CW'(1);
					end
				end
				lcdts_pkg::A_NOT_READY: st_q <= lcdts_pkg::ST_NOT_READY;
				lcdts_pkg::A_WRONG:     st_q <= lcdts_pkg::ST_WRONG;
				lcdts_pkg::A_TICK_INIT: begin
					if (init_step_q == lcdts_pkg::INIT_STEP_POWER) begin
						pins_q      <= 1'b1;
						busy_q      <= 1'b1;
						init_step_q <= 3'd1;
					end else if (init_step_q <= lcdts_pkg::INIT_STEP_LAST) begin
						if (!en_q) begin
							bus_q <= lcdts_pkg::init_cmd(init_idx);
							sel_q <= 1'b0;
							en_q  <= 1'b1;
						end else begin
							en_q        <= 1'b0;
							init_step_q <= init_step_q + 3'd1;
						end
					end else begin
						busy_q <= 1'b0;
						top_q  <= lcdts_pkg::TOP_RUN;
					end
				end
				lcdts_pkg::A_TICK_CLEAR: begin
					if (!en_q) begin
						bus_q <= lcdts_pkg::CMD_CLEAR;
						sel_q <= 1'b0;
						en_q  <= 1'b1;
					end else begin
						en_q   <= 1'b0;
						busy_q <= 1'b0;
						kind_q <= lcdts_pkg::KIND_NONE;
						sub_q  <= 1'b0;
					end
				end
				lcdts_pkg::A_TICK_CURSOR: begin
					if (!sub_q) begin
						ddram_q <= ddram_next;
						sub_q   <= 1'b1;
					end else if (!en_q) begin
						bus_q <= lcdts_pkg::CMD_SET_DDRAM | {1'b0, ddram_q};
						sel_q <= 1'b0;
						en_q  <= 1'b1;
					end else begin
						en_q   <= 1'b0;
						busy_q <= 1'b0;
						kind_q <= lcdts_pkg::KIND_NONE;
						sub_q  <= 1'b0;
					end
				end
				lcdts_pkg::A_TICK_TEXT: begin
					if (!sub_q) begin
						char_index_q <= '0;
						sub_q        <= 1'b1;
					end else if (char_index_q != text_length_q &&
						char_index_q < CW'(TEXT_DEPTH)) begin
						if (!en_q) begin
							bus_q <= rd_q;
							sel_q <= 1'b1;
							en_q  <= 1'b1;
						end else begin
							en_q         <= 1'b0;
							char_index_q <= char_index_q + CW'(1);
						end
					end else begin
						// closing tick: nothing new on the pins, busy drops
						busy_q <= 1'b0;
						kind_q <= lcdts_pkg::KIND_NONE;
						sub_q  <= 1'b0;
					end
				end
				lcdts_pkg::A_FINISH: begin
					busy_q <= 1'b0;
					kind_q <= lcdts_pkg::KIND_NONE;
					sub_q  <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	// ---------------- result register ----------------
	logic emit;
	assign emit = (uw.act == lcdts_pkg::A_EMIT) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (emit) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_status_q <= st_q;
			res_bus_q    <= bus_q;
			res_sel_q    <= sel_q;
			res_en_q     <= en_q;
			res_pins_q   <= pins_q;
			res_busy_q   <= busy_q;
			res_top_q    <= top_q;
		end
	end

	assign res.valid            = res_valid_q;
	assign res.status           = res_status_q;
	assign res.bus_data         = res_bus_q;
	assign res.reg_select       = res_sel_q;
	assign res.read_write       = 1'b0;
	assign res.enable           = res_en_q;
	assign res.pins_on          = res_pins_q;
	assign res.busy_res         = res_busy_q;
	assign res.controller_state = res_top_q;

	// ---------------- assertions ----------------
`include "char_lcd_tick_sequencer_top_macros.svh"

	`LCDTS_ASSERT_NXT(a_accept_dispatch, accept, (step_q == lcdts_pkg::S_DISP), "accepted beat not dispatched")
	`LCDTS_ASSERT_IMP(a_strobe_pins, en_q, pins_q, "E strobe high before power-on")
	`LCDTS_ASSERT_IMP(a_off_idle, (top_q == lcdts_pkg::TOP_OFF), (!busy_q && !pins_q), "busy or pins on while off")
	`LCDTS_ASSERT_IMP(a_digit_bound, (step_q == lcdts_pkg::S_NUM_DIGIT), (text_length_q < CW'(lcdts_pkg::NUM_DIGITS_MAX)), "digit loop overran")
	`LCDTS_ASSERT_IMP(a_emit_source, $rose(res_valid_q), $past(step_q == lcdts_pkg::S_EMIT), "result loaded outside emit step")

endmodule

[tb/sv/lcdts_checker.sv]
// Scoreboard for the LCD tick sequencer: predicts pin levels per request beat and checks results.
`timescale 1ns / 1ps

module lcdts_checker
	import lcdts_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	lcdts_req_if                   req,
	lcdts_res_if                   res,
	output int                     errors,
	output int                     waiting,
	output int                     checked,
	output logic                   lcd_busy,
	output int                     n_ok,
	output int                     n_not_ready,
	output int                     n_wrong,
	output int                     n_full
);

	localparam int STORE_DEPTH = TEXT_DEPTH_DEF;
	localparam logic [3:0][7:0] INIT_SEQ =
		{CMD_ENTRY_MODE, CMD_CLEAR, CMD_DISPLAY_ON, CMD_FUNCTION_SET};

	typedef struct packed {
		status_t    status;
		logic [7:0] bus;
		logic       rs;
		logic       rw;
		logic       en;
		logic       pins;
		logic       busy;
		top_state_t ctl;
	} lcd_view_t;

	// register copies
	logic [2:0] cfg_lines;
	logic [5:0] cfg_cols;
	logic [6:0] cfg_base3;
	logic [6:0] cfg_base4;

	// predicted controller state
	top_state_t top_st;
	logic [2:0] init_idx;
	logic       e_level;
	logic       busy;
	kind_t      kind;
	logic [1:0] phase;
	logic [6:0] char_pos;
	logic [6:0] str_len;
	logic [6:0] fill_pos;
	logic [6:0] ddram;
	logic [7:0] cursor_code;
	logic [7:0] text_mem [STORE_DEPTH];
	logic [7:0] bus_q;
	logic       rs_q;
	logic       pins_q;

	lcd_view_t pins_due [$];

	// E high with bus set up, then E low; returns 1 when the byte is done
	function automatic logic strobe_byte(input logic [7:0] val, input logic rs);
		if (!e_level) begin
			bus_q   = val;
			rs_q    = rs;
			e_level = 1'b1;
			return 1'b0;
		end
		e_level = 1'b0;
		return 1'b1;
	endfunction

	function automatic void close_request();
		busy  = 1'b0;
		kind  = KIND_NONE;
		phase = 2'd0;
	endfunction

	function automatic void tick_lcd();
		logic [6:0] base;
		if (top_st == TOP_INIT) begin
			if (init_idx == INIT_STEP_POWER) begin
				pins_q   = 1'b1;
				busy     = 1'b1;
				init_idx = 3'd1;
			end else if (init_idx <= INIT_STEP_LAST) begin
				if (strobe_byte(INIT_SEQ[2'(init_idx - 3'd1)], 1'b0))
					init_idx = init_idx + 3'd1;
			end else begin
				busy   = 1'b0;
				top_st = TOP_RUN;
			end
		end else if (top_st == TOP_RUN && busy) begin
			case (kind)
				KIND_CLEAR: begin
					if (strobe_byte(CMD_CLEAR, 1'b0))
						close_request();
				end
				KIND_CURSOR: begin
					if (phase == 2'd0) begin
						case (cursor_code[7:6])
							2'd0:    base = LINE1_BASE;
							2'd1:    base = LINE2_BASE;
							2'd2:    base = cfg_base3;
							default: base = cfg_base4;
						endcase
						ddram = base + {1'b0, cursor_code[5:0]};
						phase = 2'd1;
					end else if (strobe_byte(CMD_SET_DDRAM | {1'b0, ddram}, 1'b0)) begin
						close_request();
					end
				end
				KIND_TEXT, KIND_NUMBER: begin
					if (phase == 2'd0) begin
						char_pos = 7'd0;
						phase    = 2'd1;
					end else if (char_pos != str_len && char_pos < STORE_DEPTH) begin
						if (strobe_byte(text_mem[char_pos], 1'b1))
							char_pos = char_pos + 7'd1;
					end else begin
						close_request();
					end
				end
				default: close_request();
			endcase
		end
	endfunction

	function automatic void load_digits(input logic [31:0] value);
		logic [7:0]  digs [NUM_DIGITS_MAX];
		logic [31:0] n;
		int          cnt;
		n   = value;
		cnt = 0;
		do begin
			digs[cnt] = ASCII_ZERO + 8'(n % 32'd10);
			n         = n / 32'd10;
			cnt++;
		end while (n != 0 && cnt < NUM_DIGITS_MAX);
		for (int i = 0; i < cnt; i++)
			text_mem[i] = digs[cnt - 1 - i];
		str_len  = 7'(cnt);
		fill_pos = 7'd0;
		busy     = 1'b1;
		kind     = KIND_NUMBER;
		phase    = 2'd0;
	endfunction

	function automatic status_t append_text(input logic [7:0] ch, input logic last);
		status_t st;
		st = ST_OK;
		if (fill_pos < STORE_DEPTH) begin
			text_mem[fill_pos] = ch;
			fill_pos           = fill_pos + 7'd1;
		end else begin
			st = ST_FULL;
		end
		if (last) begin
			str_len  = fill_pos;
			fill_pos = 7'd0;
			busy     = 1'b1;
			kind     = KIND_TEXT;
			phase    = 2'd0;
		end
		return st;
	endfunction

	function automatic lcd_view_t lcd_pins_after(input logic [2:0] mode, input logic [1:0] row,
		input logic [5:0] column, input logic [31:0] number, input logic [7:0] ch,
		input logic last);
		status_t   st;
		logic      idle_run;
		lcd_view_t v;
		st       = ST_OK;
		idle_run = (top_st == TOP_RUN) && !busy;
		case (mode)
			MODE_TICK: tick_lcd();
			MODE_INIT: begin
				if (top_st == TOP_OFF) begin
					top_st   = TOP_INIT;
					init_idx = INIT_STEP_POWER;
				end else begin
					st = ST_NOT_READY;
				end
			end
			MODE_CLEAR, MODE_CURSOR, MODE_NUMBER, MODE_TEXT: begin
				if (!idle_run) begin
					st = ST_NOT_READY;
				end else if (mode == MODE_CLEAR) begin
					busy  = 1'b1;
					kind  = KIND_CLEAR;
					phase = 2'd0;
				end else if (mode == MODE_CURSOR) begin
					if (row >= cfg_lines || column >= cfg_cols) begin
						st = ST_WRONG;
					end else begin
						cursor_code = {row, column};
						busy        = 1'b1;
						kind        = KIND_CURSOR;
						phase       = 2'd0;
					end
				end else if (mode == MODE_NUMBER) begin
					load_digits(number);
				end else begin
					st = append_text(ch, last);
				end
			end
			default: st = ST_WRONG;
		endcase
		v.status = st;
		v.bus    = bus_q;
		v.rs     = rs_q;
		v.rw     = 1'b0;
		v.en     = e_level;
		v.pins   = pins_q;
		v.busy   = busy;
		v.ctl    = top_st;
		return v;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		lcd_view_t want;
		lcd_view_t got;
		if (!arst_n) begin
			cfg_lines   = LINE_COUNT_RST;
			cfg_cols    = COLUMN_COUNT_RST;
			cfg_base3   = LINE3_BASE_RST;
			cfg_base4   = LINE4_BASE_RST;
			top_st      = TOP_OFF;
			init_idx    = INIT_STEP_POWER;
			e_level     = 1'b0;
			busy        = 1'b0;
			kind        = KIND_NONE;
			phase       = 2'd0;
			char_pos    = 7'd0;
			str_len     = 7'd0;
			fill_pos    = 7'd0;
			ddram       = 7'd0;
			cursor_code = 8'd0;
			bus_q       = 8'd0;
			rs_q        = 1'b0;
			pins_q      = 1'b0;
			for (int i = 0; i < STORE_DEPTH; i++)
				text_mem[i] = 8'd0;
			pins_due.delete();
			errors      = 0;
			checked     = 0;
			n_ok        = 0;
			n_not_ready = 0;
			n_wrong     = 0;
			n_full      = 0;
			waiting  <= 0;
			lcd_busy <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_LINE_COUNT:   cfg_lines = cfg_data[2:0];
					CFG_COLUMN_COUNT: cfg_cols  = cfg_data[5:0];
					CFG_LINE3_BASE:   cfg_base3 = cfg_data[6:0];
					default:          cfg_base4 = cfg_data[6:0];
				endcase
			end
			if (req.valid && req.ready)
				pins_due.push_back(lcd_pins_after(req.mode, req.row, req.column, req.number,
					req.text_char, req.text_last));
			if (res.valid && res.ready) begin
				got.status = status_t'(res.status);
				got.bus    = res.bus_data;
				got.rs     = res.reg_select;
				got.rw     = res.read_write;
				got.en     = res.enable;
				got.pins   = res.pins_on;
				got.busy   = res.busy_res;
				got.ctl    = top_state_t'(res.controller_state);
				if (pins_due.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("result beat at %0t with nothing expected", $time);
				end else begin
					want = pins_due.pop_front();
					checked++;
					case (want.status)
						ST_OK:        n_ok++;
						ST_NOT_READY: n_not_ready++;
						ST_WRONG:     n_wrong++;
						default:      n_full++;
					endcase
					if (got !== want) begin
						errors++;
						if (errors <= 10) begin
							$display("mismatch at %0t, beat %0d:", $time, checked);
							$display("  want st=%0d bus=%02h rs=%b rw=%b e=%b on=%b busy=%b ctl=%0d",
								want.status, want.bus, want.rs, want.rw, want.en, want.pins,
								want.busy, want.ctl);
							$display("  got  st=%0d bus=%02h rs=%b rw=%b e=%b on=%b busy=%b ctl=%0d",
								got.status, got.bus, got.rs, got.rw, got.en, got.pins,
								got.busy, got.ctl);
						end
					end
				end
			end
			waiting  <= pins_due.size();
			lcd_busy <= busy;
		end
	end

endmodule

[tb/sv/tb_top.sv]
// Testbench top: drives ticks and requests into the LCD tick sequencer and gives the verdict.
`timescale 1ns / 1ps

module tb_top;
	import lcdts_pkg::*;

	// modes outside the defined set, answered with wrong_input
	localparam logic [2:0] MODE_BAD_LO = 3'd6;
	localparam logic [2:0] MODE_BAD_HI = 3'd7;

	localparam int ITEMS_PER_SETTING = 175;
	localparam int NUM_SETTINGS      = 6;

	// receiver stall styles
	typedef enum int {
		RX_OPEN,
		RX_RANDOM,
		RX_EVERY_THIRD,
		RX_BURSTY
	} rx_style_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	int   errors;
	int   waiting;
	int   checked;
	logic lcd_busy;
	int   n_ok;
	int   n_not_ready;
	int   n_wrong;
	int   n_full;

	// sender bookkeeping
	int   beats_sent    = 0;
	int   burst_left    = 0;
	int   settings_done = 0;
	int   cur_cols      = 16;
	logic long_due      = 1'b0;

	lcdts_req_if req_ch ();
	lcdts_res_if res_ch ();

	char_lcd_tick_sequencer_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req_ch),
		.res       (res_ch)
	);

	lcdts_checker lcd_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.req         (req_ch),
		.res         (res_ch),
		.errors      (errors),
		.waiting     (waiting),
		.checked     (checked),
		.lcd_busy    (lcd_busy),
		.n_ok        (n_ok),
		.n_not_ready (n_not_ready),
		.n_wrong     (n_wrong),
		.n_full      (n_full)
	);

	always #1 clk = ~clk;

	// hard stop; far beyond the slowest correct run
	initial begin
		#1_000_000;
		$display("char_lcd_tick_sequencer_top regression: fail");
		$finish;
	end

	// text bytes lean on the two extremes
	function automatic logic [7:0] rand_char();
		case ($urandom_range(0, 9))
			0:       return 8'h00;
			1:       return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// One beat on the request channel. Bursts of random length; between bursts valid
	// drops low, so valid never sees two writes in one step.
	task automatic put_beat(input logic [2:0] mode, input logic [1:0] row,
		input logic [5:0] col, input logic [31:0] num, input logic [7:0] ch,
		input logic last);
		int gap;
		if (burst_left == 0) begin
			req_ch.valid <= 1'b0;
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 4);
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 12);
		end
		burst_left--;
		req_ch.mode      <= mode;
		req_ch.row       <= row;
		req_ch.column    <= col;
		req_ch.number    <= num;
		req_ch.text_char <= ch;
		req_ch.text_last <= last;
		req_ch.valid     <= 1'b1;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		beats_sent++;
	endtask

	// a beat whose payload the block should not look at, so it gets junk
	task automatic offer_mode(input logic [2:0] mode);
		put_beat(mode, 2'($urandom_range(0, 3)), 6'($urandom_range(0, 63)), $urandom(),
			rand_char(), 1'($urandom_range(0, 1)));
	endtask

	task automatic tick_run(input int n);
		repeat (n) offer_mode(MODE_TICK);
	endtask

	// stop offering and wait for every predicted result to come back
	task automatic settle();
		req_ch.valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (waiting != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// block idle here: write all four registers back to back
	task automatic load_settings(input int lines, input int cols, input int b3, input int b4);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_LINE_COUNT;
		cfg_data  <= 7'(lines);
		@(posedge clk);
		cfg_index <= CFG_COLUMN_COUNT;
		cfg_data  <= 7'(cols);
		@(posedge clk);
		cfg_index <= CFG_LINE3_BASE;
		cfg_data  <= 7'(b3);
		@(posedge clk);
		cfg_index <= CFG_LINE4_BASE;
		cfg_data  <= 7'(b4);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		cur_cols = cols;
		settings_done++;
	endtask

	// One random scene: mostly a well-formed request followed by the ticks it needs,
	// sometimes a tick or two short (so the next request meets a busy block) or broken.
	task automatic play_scene();
		int          pick;
		int          len;
		int          need;
		int          digits;
		int          k;
		logic [31:0] val;
		logic [31:0] pw;
		logic [31:0] tmp;
		logic        broken;
		logic [1:0]  row;
		logic [5:0]  col;
		need = 0;
		pick = $urandom_range(0, 99);
		if (pick < 30) begin
			// text string; once in a while past the end of the store
			if (long_due)
				len = $urandom_range(65, 70);
			else if ($urandom_range(0, 49) == 0)
				len = $urandom_range(60, 70);
			else
				len = $urandom_range(1, 8);
			// broken string: no last flag, bytes pile up for the next one
			broken = !long_due && ($urandom_range(0, 9) == 0);
			long_due = 1'b0;
			for (k = 1; k <= len; k++)
				put_beat(MODE_TEXT, 2'($urandom_range(0, 3)), 6'($urandom_range(0, 63)),
					$urandom(), rand_char(), !broken && k == len);
			if (!broken)
				need = 2 * ((len > TEXT_DEPTH_DEF) ? TEXT_DEPTH_DEF : len) + 2;
		end else if (pick < 50) begin
			// decimal number, biased toward digit-count edges
			case ($urandom_range(0, 9))
				0:       val = 32'd0;
				1:       val = 32'hFFFF_FFFF;
				2, 3: begin
					pw = 32'd1;
					repeat ($urandom_range(1, 9)) pw = pw * 32'd10;
					val = pw - 32'($urandom_range(0, 1));
				end
				4, 5, 6: val = 32'($urandom_range(0, 999));
				default: val = $urandom();
			endcase
			put_beat(MODE_NUMBER, 2'($urandom_range(0, 3)), 6'($urandom_range(0, 63)), val,
				rand_char(), 1'($urandom_range(0, 1)));
			digits = 0;
			tmp    = val;
			do begin
				digits++;
				tmp = tmp / 32'd10;
			end while (tmp != 0);
			need = 2 * digits + 2;
		end else if (pick < 65) begin
			// cursor: half in range for the current width, half anywhere
			row = 2'($urandom_range(0, 3));
			col = $urandom_range(0, 1) ? 6'($urandom_range(0, cur_cols - 1))
				: 6'($urandom_range(0, 63));
			put_beat(MODE_CURSOR, row, col, $urandom(), rand_char(), 1'($urandom_range(0, 1)));
			need = 3;
		end else if (pick < 75) begin
			offer_mode(MODE_CLEAR);
			need = 2;
		end else if (pick < 85) begin
			// request straight into a busy block
			offer_mode(MODE_CLEAR);
			offer_mode(3'($urandom_range(MODE_CLEAR, MODE_TEXT)));
			need = 2;
		end else if (pick < 95) begin
			need = $urandom_range(1, 3);
		end else begin
			if ($urandom_range(0, 2) == 0)
				offer_mode(MODE_INIT);
			else
				offer_mode($urandom_range(0, 1) ? MODE_BAD_LO : MODE_BAD_HI);
		end
		if (need > 0) begin
			if ($urandom_range(0, 4) == 0)
				tick_run(need - $urandom_range(1, 2));
			else
				tick_run(need + $urandom_range(0, 2));
		end
	endtask

	// Receiver: stall segments of random style and length. After 400 and again after
	// 850 accepted request beats it holds ready low, so the block backs up and stalls
	// the sender, which keeps offering.
	initial begin
		int        seg_left;
		int        stall_left;
		int        hold_left;
		int        next_hold;
		int        beats_rx;
		rx_style_t style;
		seg_left   = 0;
		stall_left = 0;
		hold_left  = 0;
		next_hold  = 400;
		beats_rx   = 0;
		style      = RX_OPEN;
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (req_ch.valid && req_ch.ready)
				beats_rx++;
			if (hold_left > 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else if (beats_rx >= next_hold) begin
				hold_left = 300;
				next_hold += 450;
				res_ch.ready <= 1'b0;
			end else begin
				if (seg_left == 0) begin
					style    = rx_style_t'($urandom_range(0, 3));
					seg_left = $urandom_range(20, 200);
				end
				seg_left--;
				case (style)
					RX_OPEN:        res_ch.ready <= 1'b1;
					RX_RANDOM:      res_ch.ready <= ($urandom_range(0, 9) < 7);
					RX_EVERY_THIRD: res_ch.ready <= (seg_left % 3 != 0);
					default: begin
						if (stall_left > 0) begin
							stall_left--;
							res_ch.ready <= 1'b0;
						end else if ($urandom_range(0, 5) == 0) begin
							stall_left = $urandom_range(1, 8);
							res_ch.ready <= 1'b0;
						end else begin
							res_ch.ready <= 1'b1;
						end
					end
				endcase
			end
		end
	end

	// Stimulus and verdict.
	initial begin
		int ph;
		int phase_start;
		int guard;
		cfg_we           <= 1'b0;
		cfg_index        <= CFG_LINE_COUNT;
		cfg_data         <= '0;
		req_ch.valid     <= 1'b0;
		req_ch.mode      <= MODE_TICK;
		req_ch.row       <= '0;
		req_ch.column    <= '0;
		req_ch.number    <= '0;
		req_ch.text_char <= '0;
		req_ch.text_last <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed: power-up order and the refusals around it ---
		offer_mode(MODE_TICK);                                  // tick while off: no effect
		offer_mode(MODE_CLEAR);                                 // requests before init
		put_beat(MODE_CURSOR, 2'd0, 6'd0, 32'd0, 8'h00, 1'b0);
		put_beat(MODE_NUMBER, 2'd0, 6'd0, 32'd7, 8'h00, 1'b0);
		put_beat(MODE_TEXT, 2'd0, 6'd0, 32'd0, 8'h41, 1'b1);
		offer_mode(MODE_BAD_LO);                                // undefined modes
		offer_mode(MODE_BAD_HI);
		offer_mode(MODE_INIT);
		offer_mode(MODE_INIT);                                  // init while initialising
		tick_run(1);                                            // power-on step
		put_beat(MODE_TEXT, 2'd0, 6'd0, 32'd0, 8'hFF, 1'b1);    // text while initialising
		tick_run(9);                                            // four commands, then run
		tick_run(1);                                            // idle tick while operating
		offer_mode(MODE_INIT);                                  // init while operating
		put_beat(MODE_CURSOR, 2'd3, 6'd63, 32'd0, 8'h00, 1'b0); // out of range
		put_beat(MODE_CURSOR, 2'd1, 6'd15, 32'd0, 8'h00, 1'b0); // last legal spot
		tick_run(3);
		offer_mode(MODE_CLEAR);
		tick_run(2);

		// --- random: one run per register setting, reset values first, then the extremes ---
		for (ph = 0; ph < NUM_SETTINGS; ph++) begin
			if (ph != 0) begin
				// finish any request still in flight before touching registers
				settle();
				while (lcd_busy) begin
					tick_run(1);
					settle();
				end
				case (ph)
					1: load_settings(4, 40, 0, 127);
					2: load_settings(1, 1, 127, 0);
					3: load_settings(3, $urandom_range(2, 39), $urandom_range(0, 127),
						$urandom_range(0, 127));
					4: load_settings($urandom_range(1, 4), $urandom_range(1, 40),
						$urandom_range(0, 127), $urandom_range(0, 127));
					default: load_settings(LINE_COUNT_RST, COLUMN_COUNT_RST, LINE3_BASE_RST,
						LINE4_BASE_RST);
				endcase
			end
			// at least one string that overruns the text store
			if (ph == 1)
				long_due = 1'b1;
			phase_start = beats_sent;
			while (beats_sent - phase_start < ITEMS_PER_SETTING)
				play_scene();
		end

		// --- drain ---
		req_ch.valid <= 1'b0;
		for (guard = 0; waiting != 0 && guard < 20000; guard++)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("covered %0d request beats over %0d register settings, %0d results checked",
			beats_sent, settings_done + 1, checked);
		$display("result mix: %0d ok, %0d not ready, %0d wrong input, %0d buffer full",
			n_ok, n_not_ready, n_wrong, n_full);
		if (errors == 0 && waiting == 0) begin
			$display("char_lcd_tick_sequencer_top regression: pass");
		end else begin
			if (waiting != 0)
				$display("%0d expected result beats never arrived", waiting);
			$display("char_lcd_tick_sequencer_top regression: fail");
		end
		$finish;
	end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/lcdts_pkg.sv
hw/rtl/lcdts_req_if.sv
hw/rtl/lcdts_res_if.sv
hw/rtl/char_lcd_tick_sequencer_top.sv
tb/sv/lcdts_checker.sv
tb/sv/tb_top.sv
